FILE: hdl/assert_macros.svh
// assertion macros shared by the rtl files
// each expects a clock named clock and a reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/topk_pkg.sv
// types and constants of the top-k insertion list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package topk_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CAP_W       = 5;
   localparam int RANK_W      = 4;
   localparam int SCORE_W     = 32;
   localparam int TAG_W       = 16;

   localparam logic OP_CONSIDER = 1'b0;
   localparam logic OP_DUMP     = 1'b1;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag_first;
      logic [TAG_W-1:0]   tag_second;
      logic [TAG_W-1:0]   tag_third;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      entry_type     cand;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      entry_type         entry;
      logic              empty_res;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/topk_if.sv
// request and response channel interfaces
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface topk_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [31:0] score;
   logic [15:0] tag_first;
   logic [15:0] tag_second;
   logic [15:0] tag_third;

   modport source (output valid, op, score, tag_first, tag_second, tag_third,
                   input ready);
   modport sink   (input valid, op, score, tag_first, tag_second, tag_third,
                   output ready);
endinterface

interface topk_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  rank;
   logic [31:0] out_score;
   logic [15:0] out_tag_first;
   logic [15:0] out_tag_second;
   logic [15:0] out_tag_third;
   logic        empty_res;
   logic        last;

   modport source (output valid, rank, out_score, out_tag_first, out_tag_second,
                   out_tag_third, empty_res, last, input ready);
   modport sink   (input valid, rank, out_score, out_tag_first, out_tag_second,
                   out_tag_third, empty_res, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/topk_cell.sv
// one slot of the sorted list: holds an entry, compares, shifts
// depends on topk_pkg
`timescale 1ns / 1ps
`default_nettype none

module topk_cell
   import topk_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_ctl_type ctl,
   input  wire logic         occ,
   input  wire logic         prev_ge,
   input  wire entry_type    prev_entry,
   input  wire entry_type    next_entry,
   output entry_type         entry,
   output logic              ge
);

   entry_type entry_ff;
   entry_type entry_in;

   assign ge    = occ && (entry_ff.score >= ctl.cand.score);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CELL_HOLD: begin
            entry_in = entry_ff;
         end
         CELL_INSERT: begin
            if (ge) begin
               entry_in = entry_ff;
            end else if (prev_ge) begin
               entry_in = ctl.cand;
            end else begin
               entry_in = prev_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

FILE: hdl/topk_ctrl.sv
// fill count, capacity, dump sequencer and response register
// depends on topk_pkg, topk_if, assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module topk_ctrl
   import topk_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   topk_req_if.sink                req,
   topk_rsp_if.source              rsp,
   input  wire logic               csr_we,
   input  wire logic [CAP_W-1:0]   csr_wdata,
   input  wire entry_type          head_entry,
   input  wire logic [MAX_ENTRIES-1:0] ge,
   output logic [CNT_W-1:0]        cnt,
   output cell_ctl_type            cell_ctl
);

   state_type         state_ff,     state_in;
   logic [CNT_W-1:0]  cnt_ff,       cnt_in;
   logic [CNT_W-1:0]  cap_ff,       cap_in;
   logic [RANK_W-1:0] rank_ff,      rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff,  rsp_data_in;

   logic              req_fire;
   logic              full;
   logic              drop;
   logic              out_free;
   logic [IDX_W-1:0]  cap_idx;
   logic [CNT_W-1:0]  cnt_m1;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign full      = (cnt_ff == cap_ff);
   assign cnt_m1    = cap_ff - CNT_W'(1);
   assign cap_idx   = cnt_m1[IDX_W-1:0];
   assign drop      = full && ge[cap_idx];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cnt       = cnt_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cap_in        = cap_ff;
      rank_in       = rank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_data_in   = rsp_data_ff;
      cell_ctl.mode = CELL_HOLD;
      cell_ctl.cand = '{score: req.score, tag_first: req.tag_first,
                        tag_second: req.tag_second, tag_third: req.tag_third};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req.op == OP_DUMP) begin
                  state_in = ST_DUMP;
                  rank_in  = '0;
               end else if (!drop) begin
                  cell_ctl.mode = CELL_INSERT;
                  cnt_in        = full ? cnt_ff : cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_data_in = '{rank: '0, entry: '0, empty_res: 1'b1, last: 1'b1};
                  state_in    = ST_IDLE;
               end else begin
                  rsp_data_in   = '{rank: rank_ff, entry: head_entry, empty_res: 1'b0,
                                    last: (cnt_ff == CNT_W'(1))};
                  cell_ctl.mode = CELL_SHIFT;
                  cnt_in        = cnt_ff - CNT_W'(1);
                  rank_in       = rank_ff + RANK_W'(1);
                  if (cnt_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         cnt_in = '0;
         if (csr_wdata == '0) begin
            cap_in = CNT_W'(1);
         end else if (int'(csr_wdata) > MAX_ENTRIES) begin
            cap_in = CNT_W'(MAX_ENTRIES);
         end else begin
            cap_in = CNT_W'(csr_wdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cap_ff       <= CNT_W'(1);
         rank_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rank_ff      <= rank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.rank           = rsp_data_ff.rank;
   assign rsp.out_score      = rsp_data_ff.entry.score;
   assign rsp.out_tag_first  = rsp_data_ff.entry.tag_first;
   assign rsp.out_tag_second = rsp_data_ff.entry.tag_second;
   assign rsp.out_tag_third  = rsp_data_ff.entry.tag_third;
   assign rsp.empty_res      = rsp_data_ff.empty_res;
   assign rsp.last           = rsp_data_ff.last;

   `ASSERT_ALWAYS(a_cnt_le_cap, (cnt_ff <= cap_ff), "fill count above capacity")
   `ASSERT_ALWAYS(a_ge_prefix, ((ge & (ge + MAX_ENTRIES'(1))) == '0),
                  "list not sorted")
   `ASSERT_NEXT(a_dump_end, (state_ff == ST_DUMP && out_free && cnt_ff == CNT_W'(1)),
                (cnt_ff == '0 && state_ff == ST_IDLE), "dump did not clear list")
   `ASSERT_IMPLIES(a_empty_last, (rsp_valid_ff && rsp_data_ff.empty_res),
                   (rsp_data_ff.last && rsp_data_ff.rank == '0), "bad empty response")

endmodule

`default_nettype wire

FILE: hdl/top_k_sorted_insert_list_top.sv
// top level of the top-k insertion list: row of cells plus controller
// depends on topk_pkg, topk_if, topk_cell, topk_ctrl
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, score, tag_first, tag_second, tag_third
//   rsp      out  valid/ready   rank, out_score, out_tag_*, empty_res, last
//   csr      in   csr_we        csr_wdata (capacity)
//
// a consider request is taken every cycle while no dump runs; all cells compare in parallel
// a dump sends one response per entry, head first, as the cell row shifts toward
// the head (one response for an empty list); requests wait until it ends
// rsp stalls hold the response register and pause the dump
// synchronous reset clears count, capacity to one and the response valid
`timescale 1ns / 1ps
`default_nettype none

module top_k_sorted_insert_list_top
   import topk_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   topk_req_if.sink              req,
   topk_rsp_if.source            rsp,
   input  wire logic             csr_we,
   input  wire logic [CAP_W-1:0] csr_wdata
);

   cell_ctl_type              cell_ctl;
   logic [CNT_W-1:0]          cnt;
   logic [MAX_ENTRIES-1:0]    ge;
   logic [MAX_ENTRIES-1:0]    occ;
   entry_type                 entries [MAX_ENTRIES];

   topk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .head_entry (entries[0]),
      .ge         (ge),
      .cnt        (cnt),
      .cell_ctl   (cell_ctl)
   );

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type prev_entry;
      entry_type next_entry;
      logic      prev_ge;

      assign occ[i] = (cnt > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_entry = cell_ctl.cand;
         assign prev_ge    = 1'b1;
      end else begin : g_body
         assign prev_entry = entries[i-1];
         assign prev_ge    = ge[i-1];
      end

      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign next_entry = entries[i];
      end else begin : g_mid
         assign next_entry = entries[i+1];
      end

      topk_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .occ        (occ[i]),
         .prev_ge    (prev_ge),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (entries[i]),
         .ge         (ge[i])
      );
   end

endmodule

`default_nettype wire

FILE: sim/top_k_sorted_insert_list_top_tb.sv
// self-checking testbench for top_k_sorted_insert_list_top
// keeps its own sorted top-k list and checks every dump row against it
// depends on topk_pkg, topk_if and the top level rtl
`timescale 1ns / 1ps

module top_k_sorted_insert_list_top_tb;
   import topk_pkg::*;

   typedef struct {
      logic      op;
      entry_type cand;
   } req_item_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [CAP_W-1:0] csr_wdata;

   topk_req_if req_ch ();
   topk_rsp_if rsp_ch ();

   top_k_sorted_insert_list_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the list
   entry_type        shadow_list [MAX_ENTRIES];
   int               shadow_fill;
   logic [CAP_W-1:0] shadow_cap;

   req_item_type req_pending_q [$];
   rsp_type      dump_rows_q [$];
   req_item_type req_cur;
   int           req_pushed_cnt;
   int           req_taken_cnt;
   int           req_gap;
   int           rsp_stall;
   int           fail_cnt;
   bit           quiet_tail;

   function automatic int eff_cap();
      int cap;
      cap = int'(shadow_cap);
      if (cap < 1) cap = 1;
      if (cap > MAX_ENTRIES) cap = MAX_ENTRIES;
      return cap;
   endfunction

   function automatic void list_insert(entry_type cand);
      int cap;
      int cnt;
      int pos;
      int last_i;
      cap = eff_cap();
      cnt = shadow_fill;
      if (cnt > cap) cnt = cap;
      if (cnt == cap && cand.score <= shadow_list[cnt-1].score) return;
      pos = 0;
      while (pos < cnt && shadow_list[pos].score >= cand.score) pos++;
      if (cnt < cap) begin
         last_i = cnt;
         cnt++;
      end else begin
         last_i = cnt - 1;
      end
      for (int i = last_i; i > pos; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[pos] = cand;
      shadow_fill = cnt;
   endfunction

   function automatic void list_dump();
      rsp_type row;
      if (shadow_fill == 0) begin
         row = '0;
         row.empty_res = 1'b1;
         row.last = 1'b1;
         dump_rows_q = {dump_rows_q, row};
      end else begin
         for (int k = 0; k < shadow_fill; k++) begin
            row.rank = k[RANK_W-1:0];
            row.entry = shadow_list[k];
            row.empty_res = 1'b0;
            row.last = (k + 1 == shadow_fill);
            dump_rows_q = {dump_rows_q, row};
         end
      end
      shadow_fill = 0;
   endfunction

   task automatic push_req(logic op, logic [31:0] score, logic [15:0] t1, logic [15:0] t2,
                           logic [15:0] t3);
      req_item_type it;
      it.op = op;
      it.cand.score = score;
      it.cand.tag_first = t1;
      it.cand.tag_second = t2;
      it.cand.tag_third = t3;
      req_pending_q = {req_pending_q, it};
      req_pushed_cnt++;
   endtask

   // wait for every request and row, then let a consider settle
   task automatic drain_list();
      while (req_taken_cnt != req_pushed_cnt) @(posedge clock);
      while (dump_rows_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_cap = value;
      shadow_fill = 0;
   endtask

   task automatic random_phase(int count);
      logic [31:0] score;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 3))
            0: begin
               case ($urandom_range(0, 3))
                  0: score = 32'h0000_0000;
                  1: score = 32'hFFFF_FFFF;
                  2: score = 32'h4000_0000;
                  default: score = 32'h4000_0001;
               endcase
            end
            default: score = $urandom;
         endcase
         if ($urandom_range(0, eff_cap() + 3) == 0)
            push_req(OP_DUMP, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
         else
            push_req(OP_CONSIDER, score, 16'($urandom), 16'($urandom), 16'($urandom));
      end
      push_req(OP_DUMP, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
         fail_cnt++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken_cnt++;
            if (req_cur.op == OP_DUMP) list_dump();
            else list_insert(req_cur.cand);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (req_pending_q.size() != 0) begin
               if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                  req_gap = $urandom_range(1, 6) - 1;
                  req_ch.valid <= 1'b0;
               end else begin
                  req_cur = req_pending_q.pop_front();
                  req_ch.valid <= 1'b1;
                  req_ch.op <= req_cur.op;
                  req_ch.score <= req_cur.cand.score;
                  req_ch.tag_first <= req_cur.cand.tag_first;
                  req_ch.tag_second <= req_cur.cand.tag_second;
                  req_ch.tag_third <= req_cur.cand.tag_third;
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type row;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (dump_rows_q.size() == 0) begin
               $display("%0t unexpected response: rank %0d score %h", $time, rsp_ch.rank,
                        rsp_ch.out_score);
               fail_cnt++;
            end else begin
               row = dump_rows_q.pop_front();
               check_field("rank", 32'(row.rank), 32'(rsp_ch.rank));
               check_field("out_score", row.entry.score, rsp_ch.out_score);
               check_field("out_tag_first", 32'(row.entry.tag_first),
                           32'(rsp_ch.out_tag_first));
               check_field("out_tag_second", 32'(row.entry.tag_second),
                           32'(rsp_ch.out_tag_second));
               check_field("out_tag_third", 32'(row.entry.tag_third),
                           32'(rsp_ch.out_tag_third));
               check_field("empty_res", 32'(row.empty_res), 32'(rsp_ch.empty_res));
               check_field("last", 32'(row.last), 32'(rsp_ch.last));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(1, 6) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #3_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = OP_CONSIDER;
      req_ch.score = '0;
      req_ch.tag_first = '0;
      req_ch.tag_second = '0;
      req_ch.tag_third = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      shadow_cap = CAP_W'(1);
      shadow_fill = 0;
      req_pushed_cnt = 0;
      req_taken_cnt = 0;
      fail_cnt = 0;
      quiet_tail = 1'b0;
      for (int i = 0; i < MAX_ENTRIES; i++) shadow_list[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // capacity of one from reset: replace, drop below, drop on tie
      push_req(OP_CONSIDER, 32'd5, 16'h0001, 16'h0002, 16'h0003);
      push_req(OP_CONSIDER, 32'd3, 16'h0011, 16'h0012, 16'h0013);
      push_req(OP_CONSIDER, 32'd5, 16'h0021, 16'h0022, 16'h0023);
      push_req(OP_CONSIDER, 32'd9, 16'h0031, 16'h0032, 16'h0033);
      push_req(OP_DUMP, 32'd0, 16'h0000, 16'h0000, 16'h0000);
      push_req(OP_DUMP, 32'd0, 16'h0000, 16'h0000, 16'h0000);
      drain_list();

      // capacity zero acts as one; list left filled so the next write clears it
      write_capacity(5'd0);
      push_req(OP_CONSIDER, 32'h1000_0000, 16'hAAAA, 16'h5555, 16'h00FF);
      push_req(OP_CONSIDER, 32'h0FFF_FFFF, 16'h1234, 16'h5678, 16'h9ABC);
      push_req(OP_DUMP, 32'd0, 16'h0000, 16'h0000, 16'h0000);
      push_req(OP_CONSIDER, 32'h7777_7777, 16'h0BAD, 16'h0BAD, 16'h0BAD);
      drain_list();

      // capacity above range saturates; extremes, equal scores, dump fields ignored
      write_capacity(5'd31);
      push_req(OP_CONSIDER, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_req(OP_CONSIDER, 32'h0000_0000, 16'h0000, 16'h0000, 16'h0000);
      push_req(OP_CONSIDER, 32'h8000_0000, 16'h00A1, 16'h00A2, 16'h00A3);
      push_req(OP_CONSIDER, 32'h8000_0000, 16'h00B1, 16'h00B2, 16'h00B3);
      push_req(OP_DUMP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      drain_list();

      // full list: worst falls off, below last and equal to last are dropped
      write_capacity(5'd3);
      push_req(OP_CONSIDER, 32'd10, 16'h0010, 16'h0110, 16'h1110);
      push_req(OP_CONSIDER, 32'd20, 16'h0020, 16'h0120, 16'h1120);
      push_req(OP_CONSIDER, 32'd30, 16'h0030, 16'h0130, 16'h1130);
      push_req(OP_CONSIDER, 32'd25, 16'h0025, 16'h0125, 16'h1125);
      push_req(OP_CONSIDER, 32'd5, 16'h0005, 16'h0105, 16'h1105);
      push_req(OP_CONSIDER, 32'd20, 16'h0021, 16'h0121, 16'h1121);
      push_req(OP_DUMP, 32'd0, 16'h0000, 16'h0000, 16'h0000);
      drain_list();

      write_capacity(5'd16);
      random_phase(43);
      drain_list();
      write_capacity(5'd1);
      random_phase(43);
      drain_list();
      write_capacity(5'd5);
      random_phase(43);
      drain_list();
      write_capacity(5'd31);
      random_phase(43);
      drain_list();
      write_capacity(5'd0);
      random_phase(43);
      drain_list();
      write_capacity(CAP_W'($urandom_range(2, 15)));
      random_phase(43);
      drain_list();

      // last part without idling on either side
      write_capacity(5'd16);
      quiet_tail = 1'b1;
      random_phase(43);
      drain_list();
      repeat (20) @(posedge clock);

      if (fail_cnt == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/topk_pkg.sv
hdl/topk_if.sv
hdl/topk_cell.sv
hdl/topk_ctrl.sv
hdl/top_k_sorted_insert_list_top.sv
sim/top_k_sorted_insert_list_top_tb.sv
